FILE: rtl/agbkf_pkg.sv
// Shared types, constants and arithmetic helpers for the angle / gyro-bias Kalman filter.
// Used by agbkf_ctrl, agbkf_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package agbkf_pkg;

	// channel count default and fraction bits of Q8.24
	localparam int NUM_AXES_DEF = 2;
	localparam int FRAC_SH      = 24;

	// field widths
	localparam int ACC_W   = 25;
	localparam int GYR_W   = 28;
	localparam int Q_W     = 25;
	localparam int R_W     = 29;
	localparam int DT_W    = 25;
	localparam int CFG_W   = 29;
	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 64;

	// divider: magnitude of a 32-bit numerator shifted up by the fraction bits
	localparam int DVD_W     = 32 + FRAC_SH;
	localparam int DIV_STEPS = DVD_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_Q_ANGLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Q_GYRO  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_R_ANGLE = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DT_STEP = 2'd3;

	// reset values
	localparam logic [Q_W-1:0]  Q_ANGLE_RST = 25'd16777;
	localparam logic [Q_W-1:0]  Q_GYRO_RST  = 25'd50332;
	localparam logic [R_W-1:0]  R_ANGLE_RST = 29'd8388608;
	localparam logic [DT_W-1:0] DT_STEP_RST = 25'd167772;
	localparam logic signed [31:0] ONE_Q24  = 32'sd16777216;

	// product selected for the shared multiplier
	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_GB_DT,
		MUL_PSUM_DT,
		MUL_P11_DT,
		MUL_K0_E,
		MUL_K1_E,
		MUL_K1_P00,
		MUL_K1_P01,
		MUL_K0_P00,
		MUL_K0_P01
	} mul_sel_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M_GB,
		ST_M_PSUM,
		ST_M_P11,
		ST_DRAIN1,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_FIN,
		ST_M_K0E,
		ST_M_K1E,
		ST_M_K1P00,
		ST_M_K1P01,
		ST_M_K0P00,
		ST_M_K0P01,
		ST_DRAIN2,
		ST_WB
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic     load;
		mul_sel_t mul;
		logic     div_init;
		logic     div_step;
		logic     div_fin;
		logic     wb;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} stat_t;

	// saturate to signed 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > 48'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -48'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// round a Q8.24 product back by the fraction bits, ties up
	function automatic logic signed [47:0] rnd(input logic signed [65:0] p);
		logic signed [65:0] t;
		t = p + 66'sd8388608;
		return 48'(t >>> FRAC_SH);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/agbkf_ctrl.sv
// Sequencer for the filter: predict, divide, correct, write back.
// Depends on agbkf_pkg; drives agbkf_dp through cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module agbkf_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  agbkf_pkg::stat_t      stat,
	output agbkf_pkg::cmd_t       cmd
);

	agbkf_pkg::state_t state_q, state_d;
	logic [agbkf_pkg::DIV_CNT_W-1:0] cnt_q;

	// state register and divide step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= agbkf_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == agbkf_pkg::ST_DIV_INIT) begin
				cnt_q <= '0;
			end else if (state_q == agbkf_pkg::ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			agbkf_pkg::ST_IDLE:     if (in_valid) state_d = agbkf_pkg::ST_M_GB;
			agbkf_pkg::ST_M_GB:     state_d = agbkf_pkg::ST_M_PSUM;
			agbkf_pkg::ST_M_PSUM:   state_d = agbkf_pkg::ST_M_P11;
			agbkf_pkg::ST_M_P11:    state_d = agbkf_pkg::ST_DRAIN1;
			agbkf_pkg::ST_DRAIN1:   state_d = agbkf_pkg::ST_DIV_INIT;
			agbkf_pkg::ST_DIV_INIT: state_d = agbkf_pkg::ST_DIV;
			agbkf_pkg::ST_DIV: begin
				if (cnt_q == agbkf_pkg::DIV_CNT_W'(agbkf_pkg::DIV_STEPS - 1))
					state_d = agbkf_pkg::ST_DIV_FIN;
			end
			agbkf_pkg::ST_DIV_FIN:  state_d = agbkf_pkg::ST_M_K0E;
			agbkf_pkg::ST_M_K0E:    state_d = agbkf_pkg::ST_M_K1E;
			agbkf_pkg::ST_M_K1E:    state_d = agbkf_pkg::ST_M_K1P00;
			agbkf_pkg::ST_M_K1P00:  state_d = agbkf_pkg::ST_M_K1P01;
			agbkf_pkg::ST_M_K1P01:  state_d = agbkf_pkg::ST_M_K0P00;
			agbkf_pkg::ST_M_K0P00:  state_d = agbkf_pkg::ST_M_K0P01;
			agbkf_pkg::ST_M_K0P01:  state_d = agbkf_pkg::ST_DRAIN2;
			agbkf_pkg::ST_DRAIN2:   state_d = agbkf_pkg::ST_WB;
			agbkf_pkg::ST_WB:       if (stat.out_free) state_d = agbkf_pkg::ST_IDLE;
			default:                state_d = agbkf_pkg::ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd          = '0;
		cmd.mul      = agbkf_pkg::MUL_NONE;
		in_ready     = 1'b0;
		unique case (state_q)
			agbkf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			agbkf_pkg::ST_M_GB:     cmd.mul = agbkf_pkg::MUL_GB_DT;
			agbkf_pkg::ST_M_PSUM:   cmd.mul = agbkf_pkg::MUL_PSUM_DT;
			agbkf_pkg::ST_M_P11:    cmd.mul = agbkf_pkg::MUL_P11_DT;
			agbkf_pkg::ST_DRAIN1:   ;
			agbkf_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
			agbkf_pkg::ST_DIV:      cmd.div_step = 1'b1;
			agbkf_pkg::ST_DIV_FIN:  cmd.div_fin = 1'b1;
			agbkf_pkg::ST_M_K0E:    cmd.mul = agbkf_pkg::MUL_K0_E;
			agbkf_pkg::ST_M_K1E:    cmd.mul = agbkf_pkg::MUL_K1_E;
			agbkf_pkg::ST_M_K1P00:  cmd.mul = agbkf_pkg::MUL_K1_P00;
			agbkf_pkg::ST_M_K1P01:  cmd.mul = agbkf_pkg::MUL_K1_P01;
			agbkf_pkg::ST_M_K0P00:  cmd.mul = agbkf_pkg::MUL_K0_P00;
			agbkf_pkg::ST_M_K0P01:  cmd.mul = agbkf_pkg::MUL_K0_P01;
			agbkf_pkg::ST_DRAIN2:   ;
			agbkf_pkg::ST_WB:       cmd.wb = stat.out_free;
			default:                ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/agbkf_dp.sv
// Datapath: per-channel state, config registers, shared multiplier, two dividers,
// output register. Depends on agbkf_pkg; steered by agbkf_ctrl.
`timescale 1ns / 1ps
`default_nettype none
module agbkf_dp #(
	parameter int NUM_AXES = agbkf_pkg::NUM_AXES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  agbkf_pkg::cmd_t                      cmd,
	output agbkf_pkg::stat_t                     stat,
	input  wire                                  cfg_we,
	input  wire [agbkf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [agbkf_pkg::CFG_W-1:0]           cfg_data,
	input  wire                                  in_axis,
	input  wire signed [agbkf_pkg::ACC_W-1:0]    in_acc,
	input  wire signed [agbkf_pkg::GYR_W-1:0]    in_gyr,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic                                 out_axis,
	output logic signed [31:0]                   out_angle,
	output logic signed [31:0]                   out_bias
);

	localparam int AXW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
	localparam int DVD_W = agbkf_pkg::DVD_W;

	// configuration
	logic [agbkf_pkg::Q_W-1:0]  q_angle_q, q_gyro_q;
	logic [agbkf_pkg::R_W-1:0]  r_angle_q;
	logic [agbkf_pkg::DT_W-1:0] dt_q;

	// per-channel state
	logic signed [31:0] ang_mem_q [NUM_AXES];
	logic signed [31:0] bias_mem_q[NUM_AXES];
	logic signed [31:0] p00_mem_q [NUM_AXES];
	logic signed [31:0] p01_mem_q [NUM_AXES];
	logic signed [31:0] p10_mem_q [NUM_AXES];
	logic signed [31:0] p11_mem_q [NUM_AXES];

	// working registers
	logic                        ax_q;
	logic signed [agbkf_pkg::ACC_W-1:0] acc_q;
	logic signed [agbkf_pkg::GYR_W-1:0] gyr_q;
	logic signed [31:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q, e_q, k0_q, k1_q;
	logic               den_pos_q;
	logic [32:0]        dvs_q;
	logic [DVD_W-1:0]   dvd_q[2];
	logic [31:0]        rem_q[2];
	logic               neg_q[2];

	// multiplier
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod_s1;
	agbkf_pkg::mul_sel_t mul_s1;
	logic signed [47:0] rp;

	logic [AXW-1:0]     ld_idx, wb_idx;
	logic               ax_ok;
	logic signed [33:0] den;
	logic signed [32:0] dt_ext;

	assign ld_idx = AXW'(in_axis);
	assign wb_idx = AXW'(ax_q);
	assign ax_ok  = (32'(ax_q) < 32'(NUM_AXES));
	assign dt_ext = $signed({8'b0, dt_q});
	assign den    = 34'(p00_q) + $signed({5'b0, r_angle_q});
	assign rp     = agbkf_pkg::rnd(prod_s1);
	assign stat.out_free = !out_valid || out_ready;

	// gain from quotient magnitude and numerator sign
	function automatic logic signed [31:0] gain(input logic [DVD_W-1:0] q, input logic neg,
		input logic pos);
		logic signed [31:0] g;
		if (!pos) begin
			g = '0;
		end else if (neg) begin
			g = (q > DVD_W'(64'd2147483648)) ? 32'sh80000000 : 32'(32'd0 - q[31:0]);
		end else begin
			g = (q > DVD_W'(64'd2147483647)) ? 32'sh7fffffff : q[31:0];
		end
		return g;
	endfunction

	// operand selection
	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.mul)
			agbkf_pkg::MUL_NONE:    ;
			agbkf_pkg::MUL_GB_DT: begin
				ma = 33'(gyr_q) - 33'(bias_q);
				mb = dt_ext;
			end
			agbkf_pkg::MUL_PSUM_DT: begin
				ma = 33'(p01_q) + 33'(p10_q);
				mb = dt_ext;
			end
			agbkf_pkg::MUL_P11_DT: begin
				ma = 33'(p11_q);
				mb = dt_ext;
			end
			agbkf_pkg::MUL_K0_E: begin
				ma = 33'(k0_q);
				mb = 33'(e_q);
			end
			agbkf_pkg::MUL_K1_E: begin
				ma = 33'(k1_q);
				mb = 33'(e_q);
			end
			agbkf_pkg::MUL_K1_P00: begin
				ma = 33'(k1_q);
				mb = 33'(p00_q);
			end
			agbkf_pkg::MUL_K1_P01: begin
				ma = 33'(k1_q);
				mb = 33'(p01_q);
			end
			agbkf_pkg::MUL_K0_P00: begin
				ma = 33'(k0_q);
				mb = 33'(p00_q);
			end
			agbkf_pkg::MUL_K0_P01: begin
				ma = 33'(k0_q);
				mb = 33'(p01_q);
			end
			default: ;
		endcase
	end

	// config registers, state memories and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_angle_q <= agbkf_pkg::Q_ANGLE_RST;
			q_gyro_q  <= agbkf_pkg::Q_GYRO_RST;
			r_angle_q <= agbkf_pkg::R_ANGLE_RST;
			dt_q      <= agbkf_pkg::DT_STEP_RST;
			mul_s1    <= agbkf_pkg::MUL_NONE;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ang_mem_q[i]  <= '0;
				bias_mem_q[i] <= '0;
				p00_mem_q[i]  <= agbkf_pkg::ONE_Q24;
				p01_mem_q[i]  <= '0;
				p10_mem_q[i]  <= '0;
				p11_mem_q[i]  <= agbkf_pkg::ONE_Q24;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					agbkf_pkg::CFG_Q_ANGLE: q_angle_q <= cfg_data[agbkf_pkg::Q_W-1:0];
					agbkf_pkg::CFG_Q_GYRO:  q_gyro_q  <= cfg_data[agbkf_pkg::Q_W-1:0];
					agbkf_pkg::CFG_R_ANGLE: r_angle_q <= cfg_data;
					agbkf_pkg::CFG_DT_STEP: dt_q      <= cfg_data[agbkf_pkg::DT_W-1:0];
					default: ;
				endcase
			end
			mul_s1 <= cmd.mul;
			if (cmd.wb) begin
				out_valid <= 1'b1;
				if (ax_ok) begin
					ang_mem_q[wb_idx]  <= ang_q;
					bias_mem_q[wb_idx] <= bias_q;
					p00_mem_q[wb_idx]  <= p00_q;
					p01_mem_q[wb_idx]  <= p01_q;
					p10_mem_q[wb_idx]  <= p10_q;
					p11_mem_q[wb_idx]  <= p11_q;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// working registers: load, multiply, accumulate, divide
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (cmd.load) begin
			ax_q   <= in_axis;
			acc_q  <= in_acc;
			gyr_q  <= in_gyr;
			ang_q  <= ang_mem_q[ld_idx];
			bias_q <= bias_mem_q[ld_idx];
			p00_q  <= p00_mem_q[ld_idx];
			p01_q  <= p01_mem_q[ld_idx];
			p10_q  <= p10_mem_q[ld_idx];
			p11_q  <= p11_mem_q[ld_idx];
		end
		// fold in the product issued last cycle
		unique case (mul_s1)
			agbkf_pkg::MUL_NONE:    ;
			agbkf_pkg::MUL_GB_DT:   ang_q <= agbkf_pkg::sat32(48'(ang_q) + rp);
			agbkf_pkg::MUL_PSUM_DT:
				p00_q <= agbkf_pkg::sat32(48'(p00_q) + 48'(q_angle_q) - rp);
			agbkf_pkg::MUL_P11_DT: begin
				p01_q <= agbkf_pkg::sat32(48'(p01_q) - rp);
				p10_q <= agbkf_pkg::sat32(48'(p10_q) - rp);
				p11_q <= agbkf_pkg::sat32(48'(p11_q) + 48'(q_gyro_q));
			end
			agbkf_pkg::MUL_K0_E:    ang_q  <= agbkf_pkg::sat32(48'(ang_q) + rp);
			agbkf_pkg::MUL_K1_E:    bias_q <= agbkf_pkg::sat32(48'(bias_q) + rp);
			agbkf_pkg::MUL_K1_P00:  p10_q  <= agbkf_pkg::sat32(48'(p10_q) - rp);
			agbkf_pkg::MUL_K1_P01:  p11_q  <= agbkf_pkg::sat32(48'(p11_q) - rp);
			agbkf_pkg::MUL_K0_P00:  p00_q  <= agbkf_pkg::sat32(48'(p00_q) - rp);
			agbkf_pkg::MUL_K0_P01:  p01_q  <= agbkf_pkg::sat32(48'(p01_q) - rp);
			default: ;
		endcase
		// innovation and divider set-up from the predicted values
		if (cmd.div_init) begin
			e_q       <= agbkf_pkg::sat32(48'(acc_q) - 48'(ang_q));
			den_pos_q <= (den > 34'sd0);
			dvs_q     <= den[32:0];
			neg_q[0]  <= p00_q[31];
			neg_q[1]  <= p10_q[31];
			dvd_q[0]  <= {(p00_q[31] ? 32'(-p00_q) : 32'(p00_q)), {agbkf_pkg::FRAC_SH{1'b0}}};
			dvd_q[1]  <= {(p10_q[31] ? 32'(-p10_q) : 32'(p10_q)), {agbkf_pkg::FRAC_SH{1'b0}}};
			rem_q[0]  <= '0;
			rem_q[1]  <= '0;
		end
		// one restoring step per cycle in each divider
		if (cmd.div_step) begin
			for (int u = 0; u < 2; u++) begin
				if ({rem_q[u], dvd_q[u][DVD_W-1]} >= dvs_q) begin
					rem_q[u] <= 32'({rem_q[u], dvd_q[u][DVD_W-1]} - dvs_q);
					dvd_q[u] <= {dvd_q[u][DVD_W-2:0], 1'b1};
				end else begin
					rem_q[u] <= {rem_q[u][30:0], dvd_q[u][DVD_W-1]};
					dvd_q[u] <= {dvd_q[u][DVD_W-2:0], 1'b0};
				end
			end
		end
		if (cmd.div_fin) begin
			k0_q <= gain(dvd_q[0], neg_q[0], den_pos_q);
			k1_q <= gain(dvd_q[1], neg_q[1], den_pos_q);
		end
		// result register
		if (cmd.wb) begin
			out_axis  <= ax_q;
			out_angle <= ax_ok ? ang_q : 32'sd0;
			out_bias  <= ax_ok ? bias_q : 32'sd0;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/angle_gyro_bias_kalman_filter.sv
// Top level of the two-state angle / gyro-bias Kalman filter.
// Depends on agbkf_pkg, agbkf_ctrl and agbkf_dp.
//
//  channel   direction  contents
//  s_axis    in         tuser: axis; tdata: accel_angle [24:0], gyro_rate [52:25]
//  m_axis    out        tuser: out_axis; tdata: filtered_angle [31:0], gyro_bias [63:32]
//  cfg       in         write enable, register index, data (no read-back)
//
// Each item goes from transfer in to result through three predict products and a drain
// state, divider set-up, 56 steps of the restoring dividers (both gains in parallel, one
// quotient bit a cycle), the gain step, six correction products through the one shared
// multiplier, a drain state and write-back. The next transfer in is taken in the cycle
// after write-back at the earliest. One item is in work at a time; the result register
// lets the next transfer in start while a result still waits, and write-back holds while
// that result is not yet taken.
// Reset clears state and config at once.
`timescale 1ns / 1ps
`default_nettype none
module angle_gyro_bias_kalman_filter #(
	parameter int NUM_AXES = agbkf_pkg::NUM_AXES_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire [agbkf_pkg::IN_DATA_W-1:0]       s_axis_tdata,  // accel_angle, gyro_rate, zero pad
	input  wire                                  s_axis_tuser,  // axis
	output logic                                 m_axis_tvalid,
	input  wire                                  m_axis_tready,
	output logic [agbkf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // filtered_angle, gyro_bias
	output logic                                 m_axis_tuser,  // out_axis
	input  wire                                  cfg_we,
	input  wire [agbkf_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [agbkf_pkg::CFG_W-1:0]           cfg_data
);

	agbkf_pkg::cmd_t  cmd;
	agbkf_pkg::stat_t stat;
	logic signed [31:0] out_angle, out_bias;

	// sequencer
	agbkf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// arithmetic and state
	agbkf_dp #(.NUM_AXES(NUM_AXES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_axis   (s_axis_tuser),
		.in_acc    ($signed(s_axis_tdata[24:0])),
		.in_gyr    ($signed(s_axis_tdata[52:25])),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_axis  (m_axis_tuser),
		.out_angle (out_angle),
		.out_bias  (out_bias)
	);

	assign m_axis_tdata = {out_bias, out_angle};

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// Self-checking testbench for the angle / gyro-bias Kalman filter top level.
// Depends on agbkf_pkg and angle_gyro_bias_kalman_filter; predicts each result in-line.
`timescale 1ns / 1ps
`default_nettype none
module tb;

	localparam int N_AX = 2;
	localparam int LATENCY = 80;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [agbkf_pkg::IN_DATA_W-1:0] s_axis_tdata;
	logic s_axis_tuser;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [agbkf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic cfg_we;
	logic [agbkf_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [agbkf_pkg::CFG_W-1:0] cfg_data;

	angle_gyro_bias_kalman_filter #(.NUM_AXES(N_AX)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// expected result of one item
	typedef struct {
		logic axis;
		logic signed [31:0] angle;
		logic signed [31:0] bias;
	} filt_out_t;

	filt_out_t expected_q[$];

	// filter state and register copies
	longint kq_angle, kq_gyro, kr_angle, kdt;
	longint est_angle[N_AX], est_bias[N_AX];
	longint c00[N_AX], c01[N_AX], c10[N_AX], c11[N_AX];

	int send_idle_pct, recv_idle_pct;
	int hold_off;
	bit failed;
	int quiet_cycles;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// round by 24 fraction bits, ties up (arithmetic shift is a floor)
	function automatic longint rnd24(input longint v);
		return (v + 64'sd8388608) >>> agbkf_pkg::FRAC_SH;
	endfunction

	function automatic longint gain(input longint num, input longint den);
		if (den <= 0) return 0;
		return clamp32((num * 64'sd16777216) / den);
	endfunction

	task automatic reset_model();
		kq_angle = agbkf_pkg::Q_ANGLE_RST;
		kq_gyro = agbkf_pkg::Q_GYRO_RST;
		kr_angle = agbkf_pkg::R_ANGLE_RST;
		kdt = agbkf_pkg::DT_STEP_RST;
		for (int i = 0; i < N_AX; i++) begin
			est_angle[i] = 0; est_bias[i] = 0;
			c00[i] = 64'sd16777216; c01[i] = 0; c10[i] = 0; c11[i] = 64'sd16777216;
		end
	endtask

	// one filter step: predict, gains, correct
	task automatic predict_filter(input logic ax, input longint acc, input longint gyr);
		longint ang, p00, p01, p10, p11, den, k0, k1, e, an, bn;
		filt_out_t r;
		r.axis = ax;
		ang = clamp32(est_angle[ax] + rnd24((gyr - est_bias[ax]) * kdt));
		p00 = clamp32(c00[ax] + kq_angle - rnd24((c01[ax] + c10[ax]) * kdt));
		p01 = clamp32(c01[ax] - rnd24(c11[ax] * kdt));
		p10 = clamp32(c10[ax] - rnd24(c11[ax] * kdt));
		p11 = clamp32(c11[ax] + kq_gyro);
		den = p00 + kr_angle;
		k0 = gain(p00, den);
		k1 = gain(p10, den);
		e = clamp32(acc - ang);
		an = clamp32(ang + rnd24(k0 * e));
		bn = clamp32(est_bias[ax] + rnd24(k1 * e));
		est_angle[ax] = an;
		est_bias[ax] = bn;
		c00[ax] = clamp32(p00 - rnd24(k0 * p00));
		c01[ax] = clamp32(p01 - rnd24(k0 * p01));
		c10[ax] = clamp32(p10 - rnd24(k1 * p00));
		c11[ax] = clamp32(p11 - rnd24(k1 * p01));
		r.angle = an[31:0];
		r.bias = bn[31:0];
		expected_q.push_back(r);
	endtask

	// send one item, predict when the transfer happens; valid stays up until the
	// next item, an idle gap before it or the drain takes it down
	task automatic send_sample(input logic ax, input logic signed [24:0] acc,
			input logic signed [27:0] gyr);
		if (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99, 0) < send_idle_pct) begin
				@(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= ax;
		s_axis_tdata <= {3'b0, gyr, acc};
		do @(posedge clk); while (!s_axis_tready);
		predict_filter(ax, longint'(acc), longint'(gyr));
		@(negedge clk);
	endtask

	// wait for all results, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	task automatic write_reg(input logic [agbkf_pkg::CFG_IDX_W-1:0] idx, input longint val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[agbkf_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		unique case (idx)
			agbkf_pkg::CFG_Q_ANGLE: kq_angle = val & 64'h1FFFFFF;
			agbkf_pkg::CFG_Q_GYRO:  kq_gyro = val & 64'h1FFFFFF;
			agbkf_pkg::CFG_R_ANGLE: kr_angle = val & 64'h1FFFFFFF;
			agbkf_pkg::CFG_DT_STEP: kdt = val & 64'h1FFFFFF;
			default: ;
		endcase
		@(negedge clk);
	endtask

	function automatic logic signed [24:0] rand_acc();
		return 25'($signed($urandom_range(23592960, 0)) - 32'sd11796480);
	endfunction

	function automatic logic signed [27:0] rand_gyr();
		int r;
		r = $urandom_range(3, 0);
		if (r == 0) return 28'($signed($urandom_range(262144000, 0)) - 32'sd131072000);
		return 28'($signed($urandom_range(2000000, 0)) - 32'sd1000000);
	endfunction

	// directed: field extremes on both channels at reset settings
	task automatic test_extremes();
		send_sample(1'b0, 25'sd0, 28'sd0);
		send_sample(1'b1, 25'sd11796480, 28'sd131072000);
		send_sample(1'b0, -25'sd11796480, -28'sd131072000);
		send_sample(1'b1, -25'sd11796480, 28'sd131072000);
		send_sample(1'b0, 25'sd11796480, -28'sd131072000);
		send_sample(1'b1, 25'sd1, -28'sd1);
		send_sample(1'b0, 25'sh0AAAAAA, 28'h5555555);
		send_sample(1'b1, -25'sh0555555, -28'sh2AAAAAA);
		drain();
	endtask

	// directed: extreme registers, large noise, huge dt, zero noise
	task automatic test_config_extremes();
		write_reg(agbkf_pkg::CFG_Q_ANGLE, 16777216);
		write_reg(agbkf_pkg::CFG_Q_GYRO, 16777216);
		write_reg(agbkf_pkg::CFG_R_ANGLE, 1);
		write_reg(agbkf_pkg::CFG_DT_STEP, 16777216);
		for (int i = 0; i < 6; i++) send_sample(i[0], rand_acc(), 28'sd131072000);
		drain();
		write_reg(agbkf_pkg::CFG_Q_ANGLE, 0);
		write_reg(agbkf_pkg::CFG_Q_GYRO, 0);
		write_reg(agbkf_pkg::CFG_R_ANGLE, 268435456);
		write_reg(agbkf_pkg::CFG_DT_STEP, 1);
		for (int i = 0; i < 6; i++) send_sample(i[0], rand_acc(), -28'sd131072000);
		drain();
		// index past the list is a no-op in practice; all indexes are defined here
		write_reg(agbkf_pkg::CFG_Q_ANGLE, agbkf_pkg::Q_ANGLE_RST);
		write_reg(agbkf_pkg::CFG_Q_GYRO, agbkf_pkg::Q_GYRO_RST);
		write_reg(agbkf_pkg::CFG_R_ANGLE, agbkf_pkg::R_ANGLE_RST);
		write_reg(agbkf_pkg::CFG_DT_STEP, agbkf_pkg::DT_STEP_RST);
	endtask

	// random items under a given idling pattern and random settings
	task automatic test_random(input int n, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		write_reg(agbkf_pkg::CFG_Q_ANGLE, $urandom_range(16777216, 0));
		write_reg(agbkf_pkg::CFG_Q_GYRO, $urandom_range(16777216, 0));
		write_reg(agbkf_pkg::CFG_R_ANGLE, $urandom_range(268435456, 1));
		write_reg(agbkf_pkg::CFG_DT_STEP, $urandom_range(1677722, 1));
		for (int i = 0; i < n; i++) send_sample(1'($urandom_range(1, 0)), rand_acc(), rand_gyr());
		drain();
	endtask

	// receiver holds off long enough for the input to stall
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 600;
		for (int i = 0; i < 10; i++) send_sample(1'($urandom_range(1, 0)), rand_acc(), rand_gyr());
		drain();
	endtask

	// receiver ready pattern
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
		end
	end

	// result check on each output transfer
	always @(posedge clk) begin
		filt_out_t x;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected result transfer");
				failed = 1'b1;
			end else begin
				x = expected_q.pop_front();
				if (m_axis_tuser !== x.axis) begin
					$error("out_axis exp %0d got %0d", x.axis, m_axis_tuser);
					failed = 1'b1;
				end
				if ($signed(m_axis_tdata[31:0]) !== x.angle) begin
					$error("filtered_angle exp %0d got %0d", x.angle,
						$signed(m_axis_tdata[31:0]));
					failed = 1'b1;
				end
				if ($signed(m_axis_tdata[63:32]) !== x.bias) begin
					$error("gyro_bias exp %0d got %0d", x.bias, $signed(m_axis_tdata[63:32]));
					failed = 1'b1;
				end
			end
		end
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off = 0;
		failed = 1'b0;
		quiet_cycles = 0;
		reset_model();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_extremes();
		test_config_extremes();
		test_random(170, 19, 50);
		test_random(170, 50, 19);
		test_random(160, 0, 0);
		test_backpressure();
		if (expected_q.size() != 0) failed = 1'b1;
		if (!failed) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
`default_nettype wire

FILE: files.f
rtl/agbkf_pkg.sv
rtl/agbkf_ctrl.sv
rtl/agbkf_dp.sv
rtl/angle_gyro_bias_kalman_filter.sv
tb/sv/tb.sv
